// ===== design/cpu_usage_trend_recorder_top_defines.svh =====
// assertion macros shared by the cpu usage trend recorder checker
`ifndef CPU_USAGE_TREND_RECORDER_TOP_DEFINES_SVH
`define CPU_USAGE_TREND_RECORDER_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define CUTR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off while rst_n is low
`define CUTR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/cutr_pkg.sv =====
// types and constants of the cpu usage trend recorder
`timescale 1ns / 1ps
package cutr_pkg;

  localparam int unsigned ENTRY_W = 59;

  localparam logic [9:0]  PERMILLE_FULL = 10'd1000;
  localparam logic [31:0] COUNT_MAX     = 32'hFFFF_FFFF;
  localparam logic [3:0]  DIV_LAST_STEP = 4'd9;

  typedef struct packed {
    logic        restart;
    logic        reading_ok;
    logic [63:0] busy_time_ns;
    logic [63:0] wall_clock_ns;
    logic [47:0] stamp_ms;
  } cutr_in_t;

  typedef struct packed {
    logic [10:0] slot;
    logic [9:0]  usage_pmil;
    logic        usage_valid;
    logic [11:0] fill_count;
    logic        overrun;
    logic [31:0] total_readings;
    logic [31:0] valid_readings;
    logic [9:0]  usage_low;
    logic [9:0]  usage_high;
    logic [9:0]  usage_mean;
  } cutr_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCALE,
    ST_UDIV,
    ST_STATS,
    ST_MSET,
    ST_MDIV,
    ST_COMMIT
  } cutr_state_t;

endpackage

// ===== design/cpu_usage_trend_recorder_top.sv =====
// top level of the cpu usage trend recorder
`timescale 1ns / 1ps
// cpu usage trend recorder
// - input channel in_valid / in_stall / in_data: one counter reading per transfer
//   (busy and wall nanosecond counters, millisecond stamp, reading_ok, restart)
// - result channel out_valid / out_stall / out_data: one result per reading, with
//   the ring slot written, the usage in permille and the running statistics
// - cfg_wr_en / cfg_wr_data write ring_depth (0 or above RING_ENTRIES: full ring);
//   write it only while no reading is in flight
// - a reading is taken only in the idle state; in_stall is high from the transfer
//   until the result has been loaded into the output register
// - a reading passes the eval, scale, stats, mset and commit states; the shared 10-step
//   shift-subtract divider adds the usage quotient and then the mean quotient, each
//   only when it is needed
// - the next reading may be taken the cycle after its result is loaded, even
//   while that result still waits on a stalled receiver
// - a stalled result holds out_data; a finished reading waits in the commit state
//   until the output register is free, and in_stall stays high meanwhile
// - synchronous reset clears ring position, counts, statistics, the previous
//   reading and ring_depth; ring memory contents are not cleared (never read out)
module cpu_usage_trend_recorder_top #(
  parameter int RING_ENTRIES = 2048
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cutr_pkg::cutr_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cutr_pkg::cutr_out_t out_data,
  input  logic                cfg_wr_en,
  input  logic [11:0]         cfg_wr_data
);
  import cutr_pkg::*;

  // ring address width and width of counts that must hold RING_ENTRIES itself
  localparam int AW = (RING_ENTRIES > 2) ? $clog2(RING_ENTRIES) : 1;
  localparam int CW = $clog2(RING_ENTRIES + 1);
  localparam int DW = (CW > 12) ? CW : 12;

  // ring of stored entries: {valid, usage, stamp}
  logic [ENTRY_W-1:0] ring_mem [RING_ENTRIES];
  logic               mem_we;

  cutr_state_t state_r, state_nxt;

  // control and run state
  logic [11:0]   ring_depth_r, ring_depth_nxt;
  logic [AW-1:0] write_pos_r, write_pos_nxt;
  logic [DW-1:0] held_r, held_nxt;
  logic          overrun_r, overrun_nxt;
  logic [31:0]   total_r, total_nxt;
  logic [31:0]   vtot_r, vtot_nxt;
  logic [41:0]   sum_r, sum_nxt;
  logic [9:0]    min_r, min_nxt;
  logic [9:0]    max_r, max_nxt;
  logic [63:0]   prev_busy_r, prev_busy_nxt;
  logic [63:0]   prev_wall_r, prev_wall_nxt;
  logic          prev_present_r, prev_present_nxt;
  logic          out_valid_r, out_valid_nxt;

  // per-reading working registers
  cutr_in_t      item_r, item_nxt;
  logic [AW-1:0] slot_r, slot_nxt;
  logic          uvalid_r, uvalid_nxt;
  logic [63:0]   bd_r, bd_nxt;
  logic [63:0]   wd_r, wd_nxt;
  logic [9:0]    usage_r, usage_nxt;
  logic [9:0]    mean_r, mean_nxt;
  logic [73:0]   rem_r, rem_nxt;
  logic [73:0]   div_r, div_nxt;
  logic [9:0]    quo_r, quo_nxt;
  logic [3:0]    cnt_r, cnt_nxt;
  cutr_out_t     out_data_r, out_data_nxt;

  // helpers
  logic [DW-1:0] depth_w;
  logic [DW-1:0] cfg_ext;
  logic [AW-1:0] slot_w;
  logic          div_ge;
  logic [73:0]   rem_step;
  logic [9:0]    quo_step;
  logic [73:0]   bd_ext;
  logic [73:0]   bd_scaled;
  logic [31:0]   vtot_after;
  logic          out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // depth in use: zero or oversized means the whole ring
  assign cfg_ext = DW'(ring_depth_r);
  assign depth_w = ((ring_depth_r == 12'd0) || (cfg_ext > DW'(RING_ENTRIES))) ?
                   DW'(RING_ENTRIES) : cfg_ext;

  // slot wraps to 0 when the depth was lowered to or below the write position
  assign slot_w = (DW'(write_pos_r) < depth_w) ? write_pos_r : '0;

  // one restoring divide step, quotient bit per cycle
  assign div_ge   = (rem_r >= div_r);
  assign rem_step = div_ge ? (rem_r - div_r) : rem_r;
  assign quo_step = {quo_r[8:0], div_ge};

  // busy delta times 1000 = x*1024 - x*32 + x*8, exact in 74 bits
  assign bd_ext    = {10'd0, bd_r};
  assign bd_scaled = (bd_ext << 10) - (bd_ext << 5) + (bd_ext << 3);

  assign out_free = !out_valid_r || !out_stall;
  assign mem_we   = (state_r == ST_COMMIT) && out_free;

  always_comb begin
    state_nxt        = state_r;
    ring_depth_nxt   = cfg_wr_en ? cfg_wr_data : ring_depth_r;
    write_pos_nxt    = write_pos_r;
    held_nxt         = held_r;
    overrun_nxt      = overrun_r;
    total_nxt        = total_r;
    vtot_nxt         = vtot_r;
    sum_nxt          = sum_r;
    min_nxt          = min_r;
    max_nxt          = max_r;
    prev_busy_nxt    = prev_busy_r;
    prev_wall_nxt    = prev_wall_r;
    prev_present_nxt = prev_present_r;
    item_nxt         = item_r;
    slot_nxt         = slot_r;
    uvalid_nxt       = uvalid_r;
    bd_nxt           = bd_r;
    wd_nxt           = wd_r;
    usage_nxt        = usage_r;
    mean_nxt         = mean_r;
    rem_nxt          = rem_r;
    div_nxt          = div_r;
    quo_nxt          = quo_r;
    cnt_nxt          = cnt_r;
    out_data_nxt     = out_data_r;
    out_valid_nxt    = out_valid_r && out_stall;
    vtot_after       = vtot_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = ST_EVAL;
          // restart clears the run before this reading is handled
          if (in_data.restart) begin
            write_pos_nxt    = '0;
            held_nxt         = '0;
            overrun_nxt      = 1'b0;
            total_nxt        = '0;
            vtot_nxt         = '0;
            sum_nxt          = '0;
            min_nxt          = '0;
            max_nxt          = '0;
            prev_busy_nxt    = '0;
            prev_wall_nxt    = '0;
            prev_present_nxt = 1'b0;
          end
        end
      end

      ST_EVAL: begin
        uvalid_nxt = item_r.reading_ok && prev_present_r &&
                     (item_r.busy_time_ns >= prev_busy_r) &&
                     (item_r.wall_clock_ns > prev_wall_r);
        bd_nxt = item_r.busy_time_ns - prev_busy_r;
        wd_nxt = item_r.wall_clock_ns - prev_wall_r;
        if (item_r.reading_ok) begin
          prev_busy_nxt    = item_r.busy_time_ns;
          prev_wall_nxt    = item_r.wall_clock_ns;
          prev_present_nxt = 1'b1;
        end
        slot_nxt      = slot_w;
        write_pos_nxt = ((DW'(slot_w) + DW'(1)) >= depth_w) ? '0 : (slot_w + AW'(1));
        if (held_r < depth_w) begin
          held_nxt = held_r + DW'(1);
        end else begin
          held_nxt    = depth_w;
          overrun_nxt = 1'b1;
        end
        if (total_r != COUNT_MAX) begin
          total_nxt = total_r + 32'd1;
        end
        state_nxt = ST_SCALE;
      end

      ST_SCALE: begin
        if (!uvalid_r) begin
          usage_nxt = '0;
          state_nxt = ST_STATS;
        end else if (bd_r >= wd_r) begin
          usage_nxt = PERMILLE_FULL;
          state_nxt = ST_STATS;
        end else begin
          // quotient below 1000, so ten steps from divisor * 512 suffice
          rem_nxt   = bd_scaled;
          div_nxt   = {1'b0, wd_r, 9'd0};
          quo_nxt   = '0;
          cnt_nxt   = DIV_LAST_STEP;
          state_nxt = ST_UDIV;
        end
      end

      ST_UDIV: begin
        rem_nxt = rem_step;
        div_nxt = div_r >> 1;
        quo_nxt = quo_step;
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_r == 4'd0) begin
          usage_nxt = quo_step;
          state_nxt = ST_STATS;
        end
      end

      ST_STATS: begin
        if (uvalid_r) begin
          // saturated valid count freezes the sum and so the mean
          if (vtot_r != COUNT_MAX) begin
            vtot_after = vtot_r + 32'd1;
            sum_nxt    = sum_r + 42'(usage_r);
          end
          vtot_nxt = vtot_after;
          if ((vtot_after == 32'd1) || (usage_r < min_r)) begin
            min_nxt = usage_r;
          end
          if ((vtot_after == 32'd1) || (usage_r > max_r)) begin
            max_nxt = usage_r;
          end
        end
        state_nxt = ST_MSET;
      end

      ST_MSET: begin
        if (vtot_r == 32'd0) begin
          mean_nxt  = '0;
          state_nxt = ST_COMMIT;
        end else begin
          // mean never exceeds 1000, ten steps again
          rem_nxt   = {32'd0, sum_r};
          div_nxt   = {33'd0, vtot_r, 9'd0};
          quo_nxt   = '0;
          cnt_nxt   = DIV_LAST_STEP;
          state_nxt = ST_MDIV;
        end
      end

      ST_MDIV: begin
        rem_nxt = rem_step;
        div_nxt = div_r >> 1;
        quo_nxt = quo_step;
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_r == 4'd0) begin
          mean_nxt  = quo_step;
          state_nxt = ST_COMMIT;
        end
      end

      ST_COMMIT: begin
        // wait here until the output register can take the result
        if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.slot           = 11'(slot_r);
          out_data_nxt.usage_pmil     = usage_r;
          out_data_nxt.usage_valid    = uvalid_r;
          out_data_nxt.fill_count     = 12'(held_r);
          out_data_nxt.overrun        = overrun_r;
          out_data_nxt.total_readings = total_r;
          out_data_nxt.valid_readings = vtot_r;
          out_data_nxt.usage_low      = min_r;
          out_data_nxt.usage_high     = max_r;
          out_data_nxt.usage_mean     = mean_r;
          state_nxt                   = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      ring_depth_r   <= '0;
      write_pos_r    <= '0;
      held_r         <= '0;
      overrun_r      <= 1'b0;
      total_r        <= '0;
      vtot_r         <= '0;
      sum_r          <= '0;
      min_r          <= '0;
      max_r          <= '0;
      prev_busy_r    <= '0;
      prev_wall_r    <= '0;
      prev_present_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      ring_depth_r   <= ring_depth_nxt;
      write_pos_r    <= write_pos_nxt;
      held_r         <= held_nxt;
      overrun_r      <= overrun_nxt;
      total_r        <= total_nxt;
      vtot_r         <= vtot_nxt;
      sum_r          <= sum_nxt;
      min_r          <= min_nxt;
      max_r          <= max_nxt;
      prev_busy_r    <= prev_busy_nxt;
      prev_wall_r    <= prev_wall_nxt;
      prev_present_r <= prev_present_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // payload and divider registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    slot_r     <= slot_nxt;
    uvalid_r   <= uvalid_nxt;
    bd_r       <= bd_nxt;
    wd_r       <= wd_nxt;
    usage_r    <= usage_nxt;
    mean_r     <= mean_nxt;
    rem_r      <= rem_nxt;
    div_r      <= div_nxt;
    quo_r      <= quo_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  // ring write when the result is committed
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[slot_r] <= {uvalid_r, usage_r, item_r.stamp_ms};
    end
  end

endmodule

// ===== design/cutr_checker.sv =====
// port-level checker for the cpu usage trend recorder, with its bind
`timescale 1ns / 1ps
`include "cpu_usage_trend_recorder_top_defines.svh"
module cutr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input cutr_pkg::cutr_out_t out_data
);
  import cutr_pkg::*;

  `CUTR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `CUTR_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "second reading taken while one in flight")
  `CUTR_ASSERT_NOW(a_usage_range, out_valid, out_data.usage_pmil <= PERMILLE_FULL && out_data.usage_mean <= PERMILLE_FULL, "usage above full scale")
  `CUTR_ASSERT_NOW(a_invalid_zero, out_valid && !out_data.usage_valid, out_data.usage_pmil == 10'd0, "invalid usage not zero")
  `CUTR_ASSERT_NOW(a_stats_order, out_valid, out_data.usage_low <= out_data.usage_high && out_data.valid_readings <= out_data.total_readings, "statistics out of order")

endmodule

bind cpu_usage_trend_recorder_top cutr_checker u_cutr_checker (.*);

// ===== tb/cpu_usage_trend_recorder_top_tb.sv =====
// self-checking testbench for the cpu usage trend recorder top level
`timescale 1ns / 1ps
module cpu_usage_trend_recorder_top_tb;
  import cutr_pkg::*;

  localparam int          RING_ENTRIES    = 2048;
  localparam int          ITEMS_PER_PHASE = 180;
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  // settle time after the drain, with margin over the worst transfer-to-result time
  localparam int          SETTLE_CYCLES   = 30;

  // running statistics of the recorder, kept alongside the block
  class trend_scoreboard;
    cutr_out_t   pending_summaries[$];
    int          errors;
    logic [11:0] depth_reg;
    int unsigned write_pos;
    int unsigned held_count;
    logic        overrun_flag;
    logic [31:0] reading_total;
    logic [31:0] valid_total;
    logic [63:0] usage_sum;
    logic [9:0]  usage_min;
    logic [9:0]  usage_max;
    logic [63:0] prev_busy;
    logic [63:0] prev_wall;
    logic        prev_present;

    function new();
      errors    = 0;
      depth_reg = '0;
      clear_run();
    endfunction

    function void clear_run();
      write_pos     = 0;
      held_count    = 0;
      overrun_flag  = 1'b0;
      reading_total = '0;
      valid_total   = '0;
      usage_sum     = '0;
      usage_min     = '0;
      usage_max     = '0;
      prev_busy     = '0;
      prev_wall     = '0;
      prev_present  = 1'b0;
    endfunction

    function void set_depth(logic [11:0] value);
      depth_reg = value;
    endfunction

    function int pending();
      return pending_summaries.size();
    endfunction

    // works out the summary that one accepted reading produces
    function void note_reading(cutr_in_t r);
      int unsigned  depth_eff;
      int unsigned  slot_idx;
      logic [63:0]  busy_delta;
      logic [63:0]  wall_delta;
      logic [127:0] scaled;
      logic [127:0] quotient;
      logic [9:0]   usage;
      logic         usage_ok;
      cutr_out_t    e;
      if (r.restart) clear_run();
      depth_eff = (depth_reg == 0 || depth_reg > RING_ENTRIES) ? RING_ENTRIES : depth_reg;
      usage    = '0;
      usage_ok = 1'b0;
      if (r.reading_ok) begin
        if (prev_present && r.busy_time_ns >= prev_busy && r.wall_clock_ns > prev_wall) begin
          busy_delta = r.busy_time_ns - prev_busy;
          wall_delta = r.wall_clock_ns - prev_wall;
          if (busy_delta >= wall_delta) begin
            usage = PERMILLE_FULL;
          end else begin
            // full-width product, no wrap of the 64-bit delta
            scaled   = {64'd0, busy_delta} * 128'd1000;
            quotient = scaled / {64'd0, wall_delta};
            usage    = quotient[9:0];
          end
          usage_ok = 1'b1;
        end
        prev_busy    = r.busy_time_ns;
        prev_wall    = r.wall_clock_ns;
        prev_present = 1'b1;
      end
      slot_idx  = (write_pos < depth_eff) ? write_pos : 0;
      write_pos = (slot_idx + 1 >= depth_eff) ? 0 : slot_idx + 1;
      if (held_count < depth_eff) begin
        held_count++;
      end else begin
        held_count   = depth_eff;
        overrun_flag = 1'b1;
      end
      if (reading_total != COUNT_MAX) reading_total++;
      if (usage_ok) begin
        if (valid_total != COUNT_MAX) begin
          valid_total++;
          usage_sum += usage;
        end
        if (valid_total == 1 || usage < usage_min) usage_min = usage;
        if (valid_total == 1 || usage > usage_max) usage_max = usage;
      end
      e.slot           = slot_idx[10:0];
      e.usage_pmil     = usage;
      e.usage_valid    = usage_ok;
      e.fill_count     = held_count[11:0];
      e.overrun        = overrun_flag;
      e.total_readings = reading_total;
      e.valid_readings = valid_total;
      e.usage_low      = usage_min;
      e.usage_high     = usage_max;
      e.usage_mean     = (valid_total != 0) ? 10'(usage_sum / valid_total) : 10'd0;
      pending_summaries.push_back(e);
    endfunction

    function void compare_field(string name, logic [63:0] exp_val, logic [63:0] got_val);
      if (exp_val !== got_val) begin
        $error("%s: expected %0d, got %0d", name, exp_val, got_val);
        errors++;
      end
    endfunction

    function void check_result(cutr_out_t got);
      cutr_out_t exp_sum;
      if (pending_summaries.size() == 0) begin
        $error("summary transfer with no reading outstanding");
        errors++;
        return;
      end
      exp_sum = pending_summaries.pop_front();
      compare_field("slot", 64'(exp_sum.slot), 64'(got.slot));
      compare_field("usage_pmil", 64'(exp_sum.usage_pmil), 64'(got.usage_pmil));
      compare_field("usage_valid", 64'(exp_sum.usage_valid), 64'(got.usage_valid));
      compare_field("fill_count", 64'(exp_sum.fill_count), 64'(got.fill_count));
      compare_field("overrun", 64'(exp_sum.overrun), 64'(got.overrun));
      compare_field("total_readings", 64'(exp_sum.total_readings),
                    64'(got.total_readings));
      compare_field("valid_readings", 64'(exp_sum.valid_readings),
                    64'(got.valid_readings));
      compare_field("usage_low", 64'(exp_sum.usage_low), 64'(got.usage_low));
      compare_field("usage_high", 64'(exp_sum.usage_high), 64'(got.usage_high));
      compare_field("usage_mean", 64'(exp_sum.usage_mean), 64'(got.usage_mean));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  cutr_in_t    in_data;
  logic        out_valid;
  logic        out_stall;
  cutr_out_t   out_data;
  logic        cfg_wr_en;
  logic [11:0] cfg_wr_data;

  trend_scoreboard board;
  int unsigned     cycle_count;
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;
  // counter values of the last usable reading handed to the block
  logic [63:0]     cur_busy;
  logic [63:0]     cur_wall;
  // ring depths of the random phases: full ring (0 and 2048), one entry, and
  // drops below the running write position and fill count
  int unsigned     phase_depths [10] = '{0, 1, 2048, 2, 5, 37, 2047, 256, 3, 0};

  cpu_usage_trend_recorder_top #(
    .RING_ENTRIES(RING_ENTRIES)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // everything observed at the rising edge: register writes, reading
  // transfers into the predictor, summary transfers against it
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else if (rst_n) begin
      if (cfg_wr_en) board.set_depth(cfg_wr_data);
      if (in_valid && !in_stall) board.note_reading(in_data);
      if (out_valid && !out_stall) board.check_result(out_data);
    end
  end

  // receiver back-pressure, changed at the falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  function automatic cutr_in_t make_reading(bit rs, bit ok, logic [63:0] busy,
                                            logic [63:0] wall, logic [47:0] stamp);
    cutr_in_t r;
    r.restart       = rs;
    r.reading_ok    = ok;
    r.busy_time_ns  = busy;
    r.wall_clock_ns = wall;
    r.stamp_ms      = stamp;
    return r;
  endfunction

  // mostly steadily advancing counters with random rates; the rest is
  // unusable readings, counters going backwards, stalled wall time and noise
  function automatic cutr_in_t next_reading();
    cutr_in_t    r;
    int unsigned kind;
    logic [63:0] wall_step;
    logic [63:0] busy_step;
    kind         = $urandom_range(99);
    r.restart    = ($urandom_range(149) == 0);
    r.reading_ok = 1'b1;
    r.stamp_ms   = {16'($urandom), $urandom};
    if (kind < 6) begin
      r.reading_ok    = 1'($urandom_range(1));
      r.busy_time_ns  = {$urandom, $urandom};
      r.wall_clock_ns = {$urandom, $urandom};
    end else if (kind < 10) begin
      r.reading_ok    = 1'b0;
      r.busy_time_ns  = {$urandom, $urandom};
      r.wall_clock_ns = {$urandom, $urandom};
    end else if (kind < 14) begin
      if ($urandom_range(1)) begin
        // busy counter steps back
        r.busy_time_ns  = cur_busy - 64'($urandom_range(1, 5000));
        r.wall_clock_ns = cur_wall + 64'($urandom_range(1, 100000));
      end else begin
        // wall time stands still or steps back
        r.busy_time_ns  = cur_busy + 64'($urandom_range(0, 5000));
        r.wall_clock_ns = cur_wall - 64'($urandom_range(0, 3));
      end
    end else begin
      if ($urandom_range(19) == 0) wall_step = {$urandom, $urandom} >> $urandom_range(63);
      else wall_step = 64'($urandom_range(1, 2_000_000));
      if ($urandom_range(9) == 0) begin
        busy_step = wall_step + 64'($urandom_range(0, 1000));
      end else begin
        busy_step = (wall_step / 1000) * 64'($urandom_range(999)) +
                    64'($urandom_range(0, 999));
      end
      r.busy_time_ns  = cur_busy + busy_step;
      r.wall_clock_ns = cur_wall + wall_step;
    end
    if (r.reading_ok) begin
      cur_busy = r.busy_time_ns;
      cur_wall = r.wall_clock_ns;
    end
    return r;
  endfunction

  // one reading transfer, with an optional random gap ahead of it; valid is
  // left high after the transfer so back-to-back readings keep it high
  task automatic send_reading(cutr_in_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
  endtask

  // hold off the sender until every outstanding summary has been seen
  task automatic drain_summaries();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
  endtask

  // depth changes only with nothing in flight
  task automatic write_depth(int unsigned value);
    drain_summaries();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value[11:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_directed();
    send_idle_pct = 20;
    recv_idle_pct = 20;
    write_depth(3);
    // restart with no previous reading
    send_reading(make_reading(1'b1, 1'b1, 64'd0, 64'd0, 48'h0));
    send_reading(make_reading(1'b0, 1'b1, 64'd500, 64'd1000, 48'hFFFF_FFFF_FFFF));
    // unusable reading, previous one kept
    send_reading(make_reading(1'b0, 1'b0, '1, '1, 48'h8000_0000_0001));
    // busy delta above wall delta, clamped
    send_reading(make_reading(1'b0, 1'b1, 64'd2500, 64'd2000, 48'h0000_0000_0003));
    // busy backwards, then wall not advanced
    send_reading(make_reading(1'b0, 1'b1, 64'd100, 64'd3000, 48'h0000_0000_0004));
    send_reading(make_reading(1'b0, 1'b1, 64'd200, 64'd3000, 48'h7FFF_FFFF_FFFF));
    // idle interval
    send_reading(make_reading(1'b0, 1'b1, 64'd200, 64'd4000, 48'h0000_0000_0006));
    // huge deltas, product needs more than 64 bits
    send_reading(make_reading(1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_0000, '1,
                              48'h5555_5555_5555));
    send_reading(make_reading(1'b0, 1'b1, '1, '1, 48'hAAAA_AAAA_AAAA));
    send_reading(make_reading(1'b1, 1'b1, 64'd0, 64'd5, 48'h0000_0000_000A));
    send_reading(make_reading(1'b0, 1'b1, 64'd1, 64'd8, 48'h0000_0000_000B));
    // ring cut below both write position and fill count
    write_depth(1);
    send_reading(make_reading(1'b0, 1'b1, 64'd4, 64'd20, 48'h0000_0000_000C));
    // restart with an unusable reading leaves no previous reading
    send_reading(make_reading(1'b1, 1'b0, 64'd0, 64'd0, 48'h0000_0000_000D));
    send_reading(make_reading(1'b0, 1'b1, 64'd7, 64'd9, 48'h0000_0000_000E));
    write_depth(RING_ENTRIES);
    send_reading(make_reading(1'b0, 1'b1, 64'd8, 64'd11, 48'h0000_0000_000F));
    send_reading(make_reading(1'b0, 1'b1, 64'h8000_0000_0000_0008,
                              64'h8000_0000_0000_0010, 48'h0000_0000_0010));
    cur_busy = 64'h8000_0000_0000_0008;
    cur_wall = 64'h8000_0000_0000_0010;
  endtask

  initial begin
    int sent;
    board         = new();
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    cycle_count   = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    cur_busy      = '0;
    cur_wall      = '0;
    sent          = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    run_directed();

    // each phase change waits for every summary, so the sender pauses there
    foreach (phase_depths[p]) begin
      write_depth(phase_depths[p]);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // fast sender with a busy receiver, then the reverse, then full rate
        if (sent < 600) begin
          send_idle_pct = 15;
          recv_idle_pct = 85;
        end else if (sent < 1200) begin
          send_idle_pct = 85;
          recv_idle_pct = 15;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        send_reading(next_reading());
        sent++;
      end
    end

    drain_summaries();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
